@@ design/omx_pkg.sv @@
// Shared constants and the quarter-wave sine table for the omni-wheel X-drive mixer.
`default_nettype none

package omx_pkg;

  localparam int HEAD_OFFSET   = 135;
  localparam int QUARTER_TURN  = 90;
  localparam int HALF_TURN     = 180;
  localparam int THREE_QUARTER = 270;
  localparam int FULL_TURN     = 360;

  localparam int OUT_W    = 8;
  localparam int QUO_BITS = OUT_W - 1;
  localparam int LANES    = 4;

  localparam logic [7:0] LIM_CAP   = 8'd127;
  localparam logic [7:0] LIM_RESET = 8'd30;

  localparam int LANE_45  = 0;
  localparam int LANE_135 = 1;
  localparam int LANE_M135 = 2;
  localparam int LANE_M45 = 3;

  // round(sin(k deg) * 2^16), k = 0..90
  function automatic logic [16:0] quarter_sine(input logic [6:0] k);
    logic [16:0] v;
    unique case (k)
      7'd0:  v = 17'd0;     7'd1:  v = 17'd1144;  7'd2:  v = 17'd2287;
      7'd3:  v = 17'd3430;  7'd4:  v = 17'd4572;  7'd5:  v = 17'd5712;
      7'd6:  v = 17'd6850;  7'd7:  v = 17'd7987;  7'd8:  v = 17'd9121;
      7'd9:  v = 17'd10252; 7'd10: v = 17'd11380; 7'd11: v = 17'd12505;
      7'd12: v = 17'd13626; 7'd13: v = 17'd14742; 7'd14: v = 17'd15855;
      7'd15: v = 17'd16962; 7'd16: v = 17'd18064; 7'd17: v = 17'd19161;
      7'd18: v = 17'd20252; 7'd19: v = 17'd21336; 7'd20: v = 17'd22415;
      7'd21: v = 17'd23486; 7'd22: v = 17'd24550; 7'd23: v = 17'd25607;
      7'd24: v = 17'd26656; 7'd25: v = 17'd27697; 7'd26: v = 17'd28729;
      7'd27: v = 17'd29753; 7'd28: v = 17'd30767; 7'd29: v = 17'd31772;
      7'd30: v = 17'd32768; 7'd31: v = 17'd33754; 7'd32: v = 17'd34729;
      7'd33: v = 17'd35693; 7'd34: v = 17'd36647; 7'd35: v = 17'd37590;
      7'd36: v = 17'd38521; 7'd37: v = 17'd39441; 7'd38: v = 17'd40348;
      7'd39: v = 17'd41243; 7'd40: v = 17'd42126; 7'd41: v = 17'd42995;
      7'd42: v = 17'd43852; 7'd43: v = 17'd44695; 7'd44: v = 17'd45525;
      7'd45: v = 17'd46341; 7'd46: v = 17'd47143; 7'd47: v = 17'd47930;
      7'd48: v = 17'd48703; 7'd49: v = 17'd49461; 7'd50: v = 17'd50203;
      7'd51: v = 17'd50931; 7'd52: v = 17'd51643; 7'd53: v = 17'd52339;
      7'd54: v = 17'd53020; 7'd55: v = 17'd53684; 7'd56: v = 17'd54332;
      7'd57: v = 17'd54963; 7'd58: v = 17'd55578; 7'd59: v = 17'd56175;
      7'd60: v = 17'd56756; 7'd61: v = 17'd57319; 7'd62: v = 17'd57865;
      7'd63: v = 17'd58393; 7'd64: v = 17'd58903; 7'd65: v = 17'd59396;
      7'd66: v = 17'd59870; 7'd67: v = 17'd60326; 7'd68: v = 17'd60764;
      7'd69: v = 17'd61183; 7'd70: v = 17'd61584; 7'd71: v = 17'd61966;
      7'd72: v = 17'd62328; 7'd73: v = 17'd62672; 7'd74: v = 17'd62997;
      7'd75: v = 17'd63303; 7'd76: v = 17'd63589; 7'd77: v = 17'd63856;
      7'd78: v = 17'd64104; 7'd79: v = 17'd64332; 7'd80: v = 17'd64540;
      7'd81: v = 17'd64729; 7'd82: v = 17'd64898; 7'd83: v = 17'd65048;
      7'd84: v = 17'd65177; 7'd85: v = 17'd65287; 7'd86: v = 17'd65376;
      7'd87: v = 17'd65446; 7'd88: v = 17'd65496; 7'd89: v = 17'd65526;
      7'd90: v = 17'd65536;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ design/omni_wheel_x_drive_mixer.sv @@
// Omni-wheel X-drive mixer: heading/speed/turn to four wheel drives with limit scaling.
// Every input transfer passes through 14 register stages, the output register included.
// Throughput: one command per cycle while out_tready is high or a stage is empty; the divider is a
// 7-step restoring pipeline, one quotient bit per stage, so no stage iterates.
// Each stage holds only while it and every stage after it are full and out_tready is low.
// Reset: synchronous active-low rst_n clears all valid bits; the drive limit resets to 30.
`default_nettype none

module omni_wheel_x_drive_mixer
  import omx_pkg::*;
#(
  parameter int TRIG_FRACTION_BITS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] move_speed, [16:8] heading_deg, [24:17] turn_rate, [31:25] zero
  input  wire logic [31:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] drive_45, [15:8] drive_135, [23:16] drive_minus_135, [31:24] drive_minus_45
  output logic [31:0]      out_tdata
);

  localparam int F   = TRIG_FRACTION_BITS;
  localparam int TW  = F + 2;
  localparam int DW  = F + 10;
  localparam int MW  = F + 9;
  localparam int NW  = MW + QUO_BITS;
  localparam int SH  = 16 - F;
  localparam logic [17:0] RND = 18'((1 << SH) >> 1);
  localparam int DIV0 = 5;
  localparam int NS   = DIV0 + QUO_BITS + 2;

  typedef struct packed {
    logic [LANES-1:0][NW-1:0]       rem;
    logic [LANES-1:0][QUO_BITS-1:0] quo;
    logic [LANES-1:0][QUO_BITS-1:0] trc;
    logic [LANES-1:0]               neg;
    logic [MW-1:0]                  dvs;
    logic                           scale;
    logic                           zero;
  } div_t;

  function automatic logic signed [TW-1:0] trig_at(input logic [8:0] ang);
    logic [6:0]             k;
    logic                   neg;
    logic [17:0]            v;
    logic [F:0]             q;
    logic signed [TW-1:0]   t;
    if (ang <= 9'(QUARTER_TURN)) begin
      k = ang[6:0];
      neg = 1'b0;
    end else if (ang <= 9'(HALF_TURN)) begin
      k = 7'(9'(HALF_TURN) - ang);
      neg = 1'b0;
    end else if (ang <= 9'(THREE_QUARTER)) begin
      k = 7'(ang - 9'(HALF_TURN));
      neg = 1'b1;
    end else begin
      k = 7'(9'(FULL_TURN) - ang);
      neg = 1'b1;
    end
    v = 18'(quarter_sine(k)) + RND;
    q = v[SH +: F + 1];
    t = $signed(TW'(q));
    return neg ? -t : t;
  endfunction

  function automatic logic in_bound(input logic [7:0] v, input logic [6:0] l);
    logic signed [7:0] sv;
    logic signed [7:0] sl;
    sv = $signed(v);
    sl = $signed({1'b0, l});
    return (sv <= sl) && (sv >= -sl);
  endfunction

  logic [7:0]    drive_cap_r;
  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS-1:0] adv;
  logic [6:0]    lim_c;

  logic [8:0]  ang0_r, angc0_r, ang0_nxt, angc0_nxt;
  logic [7:0]  spd0_r, trn0_r;
  logic signed [TW-1:0] sin1_r, cos1_r;
  logic [7:0]  spd1_r, trn1_r;
  logic [LANES-1:0][DW-1:0] drv2_r, drv2_nxt;
  logic [LANES-1:0][MW-1:0] mag3_r, mag3_nxt, mag4_r;
  logic [LANES-1:0]         neg3_r, neg4_r;
  logic [MW-1:0]            max4_r, max4_nxt;
  div_t dv_r   [0:QUO_BITS];
  div_t dv_nxt [0:QUO_BITS];
  logic [31:0] out_r, out_nxt;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      adv[k] = out_tready || !(&(vld_r | NS'((1 << k) - 1)));
    end
    vld_nxt[0] = adv[0] ? in_tvalid : vld_r[0];
    for (int k = 1; k < NS; k++) begin
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  assign in_tready  = adv[0];
  assign out_tvalid = vld_r[NS-1];
  assign out_tdata  = out_r;
  assign lim_c = (drive_cap_r > LIM_CAP) ? LIM_CAP[6:0] : drive_cap_r[6:0];

  // stage 0: heading + 135, wrapped to 0..359, and the cosine angle
  always_comb begin
    logic [10:0] h;
    logic [9:0]  c;
    h = {{2{in_tdata[16]}}, in_tdata[16:8]} + 11'(HEAD_OFFSET);
    if (h[10]) begin
      h = h + 11'(FULL_TURN);
    end else if (h >= 11'(FULL_TURN)) begin
      h = h - 11'(FULL_TURN);
    end
    ang0_nxt = h[8:0];
    c = {1'b0, ang0_nxt} + 10'(QUARTER_TURN);
    if (c >= 10'(FULL_TURN)) begin
      c = c - 10'(FULL_TURN);
    end
    angc0_nxt = c[8:0];
  end

  // stage 2: products and wheel sums
  always_comb begin
    logic signed [DW-1:0] ps, pc, rt;
    ps = DW'($signed(spd1_r)) * DW'(sin1_r);
    pc = DW'($signed(spd1_r)) * DW'(cos1_r);
    rt = DW'($signed(trn1_r)) <<< F;
    drv2_nxt[LANE_45]   = ps + rt;
    drv2_nxt[LANE_135]  = rt - pc;
    drv2_nxt[LANE_M135] = rt - ps;
    drv2_nxt[LANE_M45]  = pc + rt;
  end

  // stage 3: magnitudes
  always_comb begin
    logic signed [DW-1:0] d;
    for (int l = 0; l < LANES; l++) begin
      d = $signed(drv2_r[l]);
      mag3_nxt[l] = d[DW-1] ? MW'(-d) : MW'(d);
    end
  end

  // stage 4: largest magnitude
  always_comb begin
    logic [MW-1:0] m01, m23;
    m01 = (mag3_r[0] > mag3_r[1]) ? mag3_r[0] : mag3_r[1];
    m23 = (mag3_r[2] > mag3_r[3]) ? mag3_r[2] : mag3_r[3];
    max4_nxt = (m01 > m23) ? m01 : m23;
  end

  // stage 5: numerators |d|*L and the scaling decision
  always_comb begin
    dv_nxt[0].dvs   = max4_r;
    dv_nxt[0].scale = max4_r > (MW'(lim_c) << F);
    dv_nxt[0].zero  = (lim_c == 7'd0);
    dv_nxt[0].neg   = neg4_r;
    for (int l = 0; l < LANES; l++) begin
      dv_nxt[0].rem[l] = NW'(mag4_r[l]) * NW'(lim_c);
      dv_nxt[0].trc[l] = mag4_r[l][F + QUO_BITS - 1:F];
      dv_nxt[0].quo[l] = '0;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
    localparam int BIT = QUO_BITS - 1 - j;
    always_comb begin
      logic [NW-1:0] dsh;
      dsh = NW'(dv_r[j].dvs) << BIT;
      dv_nxt[j+1] = dv_r[j];
      for (int l = 0; l < LANES; l++) begin
        if (dv_r[j].rem[l] >= dsh) begin
          dv_nxt[j+1].rem[l]      = dv_r[j].rem[l] - dsh;
          dv_nxt[j+1].quo[l][BIT] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv[DIV0 + 1 + j]) begin
        dv_r[j+1] <= dv_nxt[j+1];
      end
    end
  end

  // output: select, apply sign
  always_comb begin
    logic [QUO_BITS-1:0] mo;
    logic [OUT_W-1:0]    v;
    for (int l = 0; l < LANES; l++) begin
      if (dv_r[QUO_BITS].zero) begin
        mo = '0;
      end else if (dv_r[QUO_BITS].scale) begin
        mo = dv_r[QUO_BITS].quo[l];
      end else begin
        mo = dv_r[QUO_BITS].trc[l];
      end
      v = {1'b0, mo};
      out_nxt[l*OUT_W +: OUT_W] = dv_r[QUO_BITS].neg[l] ? -v : v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      drive_cap_r <= LIM_RESET;
    end else begin
      vld_r <= vld_nxt;
      if (cfg_we) begin
        drive_cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ang0_r  <= ang0_nxt;
      angc0_r <= angc0_nxt;
      spd0_r  <= in_tdata[7:0];
      trn0_r  <= in_tdata[24:17];
    end
    if (adv[1]) begin
      sin1_r <= trig_at(ang0_r);
      cos1_r <= trig_at(angc0_r);
      spd1_r <= spd0_r;
      trn1_r <= trn0_r;
    end
    if (adv[2]) begin
      drv2_r <= drv2_nxt;
    end
    if (adv[3]) begin
      mag3_r <= mag3_nxt;
      for (int l = 0; l < LANES; l++) begin
        neg3_r[l] <= drv2_r[l][DW-1];
      end
    end
    if (adv[4]) begin
      mag4_r <= mag3_r;
      neg4_r <= neg3_r;
      max4_r <= max4_nxt;
    end
    if (adv[DIV0]) begin
      dv_r[0] <= dv_nxt[0];
    end
    if (adv[NS-1]) begin
      out_r <= out_nxt;
    end
  end

  a_take_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted transfer did not enter the first stage");

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  a_zero_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && lim_c == 7'd0) |-> (out_tdata == 32'd0))
    else $error("nonzero drive with zero speed limit");

  a_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (in_bound(out_tdata[7:0], lim_c) && in_bound(out_tdata[15:8], lim_c)
                 && in_bound(out_tdata[23:16], lim_c) && in_bound(out_tdata[31:24], lim_c)))
    else $error("drive exceeds speed limit");

  a_scaled_hits_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NS-2] && dv_r[QUO_BITS].scale && !dv_r[QUO_BITS].zero)
      |-> (dv_r[QUO_BITS].quo[0] == lim_c || dv_r[QUO_BITS].quo[1] == lim_c
        || dv_r[QUO_BITS].quo[2] == lim_c || dv_r[QUO_BITS].quo[3] == lim_c))
    else $error("scaled transfer has no lane at the limit");

endmodule

`default_nettype wire

@@ tb/tb_omni_wheel_x_drive_mixer.sv @@
// Testbench for omni_wheel_x_drive_mixer: directed table plus random commands, predicted drives.
`default_nettype none

module tb_omni_wheel_x_drive_mixer
  import omx_pkg::*;
();

  localparam int FRAC_BITS = 14;
  localparam int PIPE_DEPTH = 14;

  typedef enum logic {ROW_CMD, ROW_LIMIT} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  spd;
    logic [8:0]  hdg;
    logic [7:0]  trn;
    logic [7:0]  lim;
    logic        typed;
    logic [31:0] drives;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = 32'd0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;

  logic [31:0] pending_drives [$];
  logic [7:0] limit_shadow = LIM_RESET;
  int mismatch_count = 0;
  int calm_in = 0;
  int calm_out = 0;

  // round(sin(k deg) * 2^16), k = 0..90
  int sine_q16 [0:90] = '{
        0,  1144,  2287,  3430,  4572,  5712,  6850,  7987,  9121, 10252,
    11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
    22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
    32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
    42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
    50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
    56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
    61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
    64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
    65536
  };

  dir_row_t dir_rows [0:22] = '{
    '{ROW_CMD,    8'sd0,    9'sd0,     8'sd0,    8'd0,   1'b1, 32'h0000_0000},
    '{ROW_CMD,    8'sd127,  9'sd0,     8'sd0,    8'd0,   1'b1, 32'hE2E2_1E1E},
    '{ROW_CMD,    8'sd0,    9'sd0,     8'sd127,  8'd0,   1'b1, 32'h1E1E_1E1E},
    '{ROW_CMD,    8'sd0,    9'sd0,    -8'sd128,  8'd0,   1'b1, 32'hE2E2_E2E2},
    '{ROW_CMD,   -8'sd128, -9'sd256,   8'sd0,    8'd0,   1'b0, 32'h0},
    '{ROW_CMD,    8'sd127,  9'sd255,  -8'sd128,  8'd0,   1'b0, 32'h0},
    '{ROW_CMD,    8'sd100, -9'sd180,   8'sd0,    8'd0,   1'b0, 32'h0},
    '{ROW_CMD,    8'sd100,  9'sd180,   8'sd0,    8'd0,   1'b0, 32'h0},
    '{ROW_CMD,    8'sd50,  -9'sd135,   8'sd10,   8'd0,   1'b0, 32'h0},
    '{ROW_CMD,    8'sd50,   9'sd225,  -8'sd10,   8'd0,   1'b0, 32'h0},
    '{ROW_CMD,    8'sd5,    9'sd90,    8'sd3,    8'd0,   1'b0, 32'h0},
    '{ROW_LIMIT,  8'sd0,    9'sd0,     8'sd0,    8'd0,   1'b0, 32'h0},
    '{ROW_CMD,    8'sd127,  9'sd45,    8'sd127,  8'd0,   1'b1, 32'h0000_0000},
    '{ROW_CMD,   -8'sd128, -9'sd1,    -8'sd128,  8'd0,   1'b1, 32'h0000_0000},
    '{ROW_LIMIT,  8'sd0,    9'sd0,     8'sd0,    8'd255, 1'b0, 32'h0},
    '{ROW_CMD,   -8'sd128, -9'sd90,   -8'sd128,  8'd0,   1'b0, 32'h0},
    '{ROW_CMD,    8'sd127,  9'sd170,   8'sd127,  8'd0,   1'b0, 32'h0},
    '{ROW_CMD,    8'sd100,  9'sd0,     8'sd0,    8'd0,   1'b0, 32'h0},
    '{ROW_LIMIT,  8'sd0,    9'sd0,     8'sd0,    8'd128, 1'b0, 32'h0},
    '{ROW_CMD,    8'sd127, -9'sd45,   -8'sd1,    8'd0,   1'b0, 32'h0},
    '{ROW_LIMIT,  8'sd0,    9'sd0,     8'sd0,    8'd1,   1'b0, 32'h0},
    '{ROW_CMD,    8'sd1,    9'sd0,     8'sd0,    8'd0,   1'b0, 32'h0},
    '{ROW_CMD,    8'sd0,    9'sd0,     8'sd1,    8'd0,   1'b0, 32'h0}
  };

  omni_wheel_x_drive_mixer #(
    .TRIG_FRACTION_BITS(FRAC_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #10 clk = ~clk;

  function automatic longint sine_of(longint a);
    longint k;
    longint v;
    bit neg;
    neg = 1'b0;
    if (a <= QUARTER_TURN) k = a;
    else if (a <= HALF_TURN) k = HALF_TURN - a;
    else if (a <= THREE_QUARTER) begin
      k = a - HALF_TURN;
      neg = 1'b1;
    end else begin
      k = FULL_TURN - a;
      neg = 1'b1;
    end
    v = (longint'(sine_q16[k]) + (longint'(1) << (15 - FRAC_BITS))) >>> (16 - FRAC_BITS);
    return neg ? -v : v;
  endfunction

  function automatic logic [31:0] mix_drives(logic signed [7:0] spd, logic signed [8:0] hdg,
                                             logic signed [7:0] trn, logic [7:0] lim_raw);
    longint one, ang, sn, cs, lim, mx, mag, o;
    longint d [LANES];
    logic [31:0] res;
    one = longint'(1) << FRAC_BITS;
    ang = longint'(hdg) + HEAD_OFFSET;
    if (ang < 0) ang += FULL_TURN;
    if (ang >= FULL_TURN) ang -= FULL_TURN;
    sn = sine_of(ang);
    cs = sine_of((ang + QUARTER_TURN) % FULL_TURN);
    d[LANE_45]   =  longint'(spd) * sn + longint'(trn) * one;
    d[LANE_135]  = -longint'(spd) * cs + longint'(trn) * one;
    d[LANE_M135] = -longint'(spd) * sn + longint'(trn) * one;
    d[LANE_M45]  =  longint'(spd) * cs + longint'(trn) * one;
    lim = (lim_raw > LIM_CAP) ? longint'(LIM_CAP) : longint'(lim_raw);
    mx = 0;
    for (int i = 0; i < LANES; i++) begin
      mag = (d[i] < 0) ? -d[i] : d[i];
      if (mag > mx) mx = mag;
    end
    for (int i = 0; i < LANES; i++) begin
      if (lim == 0) o = 0;
      else if (mx > lim * one) o = (d[i] * lim) / mx;
      else o = d[i] / one;
      res[i*OUT_W +: OUT_W] = o[7:0];
    end
    return res;
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 59) == 0) calm = $urandom_range(10, 60);
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_cmd(logic [7:0] spd, logic [8:0] hdg, logic [7:0] trn,
                          logic typed, logic [31:0] drives);
    int gap;
    gap = pick_gap(calm_in);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, trn, hdg, spd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_drives.push_back(typed ? drives : mix_drives(spd, hdg, trn, limit_shadow));
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_drives.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [7:0] lim);
    drain();
    repeat (PIPE_DEPTH + 2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_shadow = lim;
  endtask

  initial begin : ready_gen
    int gap;
    forever begin
      @(posedge clk);
      gap = pick_gap(calm_out);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_drives
    logic [31:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_drives.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %h", $time, out_tdata);
        mismatch_count++;
      end else begin
        want = pending_drives.pop_front();
        for (int i = 0; i < LANES; i++) begin
          if (out_tdata[i*OUT_W +: OUT_W] !== want[i*OUT_W +: OUT_W]) begin
            $display("%0t: lane %0d expected %0d actual %0d", $time, i,
                     $signed(want[i*OUT_W +: OUT_W]), $signed(out_tdata[i*OUT_W +: OUT_W]));
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    #(20 * 500000);
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [7:0] spd, trn, lim;
    logic [8:0] hdg;
    int shape;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[n]) begin
      if (dir_rows[n].kind == ROW_LIMIT) write_limit(dir_rows[n].lim);
      else send_cmd(dir_rows[n].spd, dir_rows[n].hdg, dir_rows[n].trn,
                    dir_rows[n].typed, dir_rows[n].drives);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: lim = 8'd127;
        1: lim = 8'd255;
        2: lim = 8'd64;
        3: lim = 8'd1;
        4: lim = 8'd0;
        default: lim = 8'($urandom_range(0, 255));
      endcase
      write_limit(lim);
      for (int n = 0; n < 100; n++) begin
        if (ph == 2 && n == 50) drain();
        shape = $urandom_range(0, 9);
        spd = 8'($urandom);
        trn = 8'($urandom);
        hdg = 9'($urandom_range(0, 360) - 180);
        if (shape >= 6 && shape < 8) begin
          spd = 8'($urandom_range(0, 100));
          trn = 8'($urandom_range(0, 40) - 20);
        end else if (shape >= 8) begin
          hdg = 9'($urandom);
        end
        send_cmd(spd, hdg, trn, 1'b0, 32'd0);
      end
    end

    drain();
    repeat (PIPE_DEPTH + 6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
design/omx_pkg.sv
design/omni_wheel_x_drive_mixer.sv
tb/tb_omni_wheel_x_drive_mixer.sv
